@@ hdl/slink_pkg.sv @@
// shared types and constants for the single-wire link initiator
`timescale 1ns / 1ps

package slink_pkg;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_LSTOP    = 4'd1,
        PH_START    = 4'd2,
        PH_TXDATA   = 4'd3,
        PH_SSTOP    = 4'd4,
        PH_EXTRA    = 4'd5,
        PH_DMZ      = 4'd6,
        PH_WAITHI   = 4'd7,
        PH_STOPCHK  = 4'd8,
        PH_STARTCHK = 4'd9,
        PH_RXDATA   = 4'd10,
        PH_RXSTOP   = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        REG_TICKS_PER_BIT   = 2'd0,
        REG_LONG_STOP_BITS  = 2'd1,
        REG_SHORT_STOP_BITS = 2'd2,
        REG_IDLE_BITS       = 2'd3
    } reg_index_t;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int WORD_W = 24;
    localparam int TICK_W = 12;

    localparam logic [7:0] TICKS_PER_BIT_RST   = 8'd8;
    localparam logic [3:0] LONG_STOP_BITS_RST  = 4'd8;
    localparam logic [3:0] SHORT_STOP_BITS_RST = 4'd2;
    localparam logic [3:0] IDLE_BITS_RST       = 4'd8;
    localparam logic [7:0] MIN_TICKS_PER_BIT   = 8'd2;
    localparam logic [3:0] IDLE_MARGIN_BITS    = 4'd2;

    typedef struct packed {
        logic [7:0] ticks_per_bit;
        logic [3:0] lead_stop_len;
        logic [3:0] tail_stop_len;
        logic [3:0] idle_len;
    } cfg_t;

    typedef struct packed {
        logic              line_out;
        logic              drive_enable;
        logic              busy_res;
        logic              done_res;
        logic              ok;
        logic [WORD_W-1:0] rx_word;
    } res_t;

endpackage

@@ hdl/slink_if.sv @@
// valid/ready channel interfaces for input ticks and results
`timescale 1ns / 1ps

interface slink_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] tx_byte;
    logic       line_in;

    modport source (output valid, output op, output tx_byte, output line_in, input ready);
    modport sink (input valid, input op, input tx_byte, input line_in, output ready);
endinterface

interface slink_out_if;
    logic        valid;
    logic        ready;
    logic        line_out;
    logic        drive_enable;
    logic        busy_res;
    logic        done_res;
    logic        ok;
    logic [23:0] rx_word;

    modport source (output valid, output line_out, output drive_enable, output busy_res,
                    output done_res, output ok, output rx_word, input ready);
    modport sink (input valid, input line_out, input drive_enable, input busy_res,
                  input done_res, input ok, input rx_word, output ready);
endinterface

@@ hdl/slink_cfg.sv @@
// apb register file holding the link timing configuration
`timescale 1ns / 1ps

module slink_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [slink_pkg::ADDR_W-1:0]   paddr,
    input  logic [slink_pkg::DATA_W-1:0]   pwdata,
    output logic [slink_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,
    output slink_pkg::cfg_t                cfg
);
    import slink_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_bit <= TICKS_PER_BIT_RST;
            cfg_reg.lead_stop_len <= LONG_STOP_BITS_RST;
            cfg_reg.tail_stop_len <= SHORT_STOP_BITS_RST;
            cfg_reg.idle_len      <= IDLE_BITS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TICKS_PER_BIT:   cfg_reg.ticks_per_bit <= pwdata[7:0];
                REG_LONG_STOP_BITS:  cfg_reg.lead_stop_len <= pwdata[3:0];
                REG_SHORT_STOP_BITS: cfg_reg.tail_stop_len <= pwdata[3:0];
                REG_IDLE_BITS:       cfg_reg.idle_len      <= pwdata[3:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TICKS_PER_BIT:   prdata = {24'd0, cfg_reg.ticks_per_bit};
            REG_LONG_STOP_BITS:  prdata = {28'd0, cfg_reg.lead_stop_len};
            REG_SHORT_STOP_BITS: prdata = {28'd0, cfg_reg.tail_stop_len};
            REG_IDLE_BITS:       prdata = {28'd0, cfg_reg.idle_len};
        endcase
    end

endmodule

@@ hdl/single_wire_link_anchor.sv @@
// top level of the single-wire link initiator: sequencer, result register and skid stage
`timescale 1ns / 1ps

// Initiator of a half-duplex single-wire link. Every input transaction is one sampling
// tick of the wire (or a start command when idle) and yields exactly one result. The
// frame sequencer is combinational, so a transaction is accepted on every clock while
// the skid register is empty; its result is registered in the output register, or in
// the skid register if the output still holds one. A two-entry output stage (result
// plus skid register) drops input ready only when both entries are full. The user must
// write timing registers over the APB port only while idle; the block does not enforce it.
module single_wire_link_anchor #(
    parameter int TX_BITS = 8,
    parameter int RX_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [slink_pkg::ADDR_W-1:0]   paddr,
    input  logic [slink_pkg::DATA_W-1:0]   pwdata,
    output logic [slink_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,
    slink_in_if.sink                       item,
    slink_out_if.source                    result
);
    import slink_pkg::*;

    localparam int MAX_BITS = (TX_BITS > RX_BITS) ? TX_BITS : RX_BITS;
    localparam int BIT_W    = $clog2(MAX_BITS + 1);

    cfg_t cfg;

    slink_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic [BIT_W-1:0]    bit_index_reg, bit_index_next;
    logic [7:0]          tx_shift_reg, tx_shift_next;
    logic [RX_BITS-1:0]  rx_shift_reg, rx_shift_next;
    logic                error_flag_reg, error_flag_next;

    logic                out_valid_reg, skid_valid_reg;
    res_t                out_reg, skid_reg;
    res_t                res;

    logic                accept;
    logic                take;
    logic [7:0]          t;
    logic [7:0]          two_h;
    logic [TICK_W-1:0]   dur;
    logic [TICK_W-1:0]   min_idle;
    logic [TICK_W:0]     tick_inc;
    logic                elapsed;
    logic [BIT_W-1:0]    bit_inc;
    logic                done;
    logic [7:0]          tx_bits_out;
    logic [WORD_W-1:0]   word;

    assign accept = item.valid && item.ready;
    assign take   = out_valid_reg && result.ready;
    assign item.ready = !skid_valid_reg;

    // bit time and half-bit derived quantities
    assign t        = (cfg.ticks_per_bit < MIN_TICKS_PER_BIT) ? MIN_TICKS_PER_BIT
                                                              : cfg.ticks_per_bit;
    assign two_h    = {t[7:1], 1'b0};
    assign min_idle = (cfg.idle_len >= IDLE_MARGIN_BITS)
                    ? TICK_W'(cfg.idle_len - IDLE_MARGIN_BITS) * TICK_W'(t)
                    : '0;
    assign tick_inc = {1'b0, tick_count_reg} + (TICK_W+1)'(1);
    assign elapsed  = tick_inc >= {1'b0, dur};
    assign bit_inc  = bit_index_reg + BIT_W'(1);

    // duration of the current phase in ticks
    always_comb
    begin
        unique case (phase_reg)
            PH_LSTOP:    dur = TICK_W'(cfg.lead_stop_len) * TICK_W'(t);
            PH_SSTOP:    dur = TICK_W'(cfg.tail_stop_len) * TICK_W'(t);
            PH_DMZ:      dur = TICK_W'(t) << 2;
            PH_WAITHI:   dur = TICK_W'(cfg.idle_len) * TICK_W'(t);
            PH_STOPCHK:  dur = TICK_W'(t[7:1]);
            PH_STARTCHK: dur = TICK_W'(two_h);
            PH_RXDATA:   dur = (bit_index_reg == '0) ? TICK_W'(two_h) : TICK_W'(t);
            default:     dur = TICK_W'(t);
        endcase
    end

    // frame sequencer
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = elapsed ? '0 : tick_inc[TICK_W-1:0];
        bit_index_next  = bit_index_reg;
        tx_shift_next   = tx_shift_reg;
        rx_shift_next   = rx_shift_reg;
        error_flag_next = error_flag_reg;
        done            = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                tick_count_next = tick_count_reg;
                if (item.op)
                begin
                    tx_shift_next   = item.tx_byte;
                    rx_shift_next   = '0;
                    error_flag_next = 1'b0;
                    tick_count_next = '0;
                    bit_index_next  = '0;
                    phase_next      = PH_LSTOP;
                end
            end
            PH_LSTOP:
                if (elapsed) phase_next = PH_START;
            PH_START:
                if (elapsed)
                begin
                    phase_next     = PH_TXDATA;
                    bit_index_next = '0;
                end
            PH_TXDATA:
                if (elapsed)
                begin
                    bit_index_next = bit_inc;
                    if (bit_inc >= BIT_W'(TX_BITS)) phase_next = PH_SSTOP;
                end
            PH_SSTOP:
                if (elapsed) phase_next = PH_EXTRA;
            PH_EXTRA:
                if (elapsed) phase_next = PH_DMZ;
            PH_DMZ:
                if (elapsed) phase_next = PH_WAITHI;
            PH_WAITHI:
                if (item.line_in)
                begin
                    if (tick_count_reg < min_idle) error_flag_next = 1'b1;
                    tick_count_next = '0;
                    phase_next      = PH_STOPCHK;
                end
                else if (elapsed)
                begin
                    phase_next = PH_STOPCHK;
                end
            PH_STOPCHK:
                if (elapsed)
                begin
                    if (!item.line_in) error_flag_next = 1'b1;
                    phase_next = PH_STARTCHK;
                end
            PH_STARTCHK:
                if (elapsed)
                begin
                    if (item.line_in) error_flag_next = 1'b1;
                    phase_next     = PH_RXDATA;
                    bit_index_next = '0;
                end
            PH_RXDATA:
                if (elapsed)
                begin
                    if (item.line_in)
                        rx_shift_next = rx_shift_reg | (RX_BITS'(1) << bit_index_reg);
                    bit_index_next = bit_inc;
                    if (bit_inc >= BIT_W'(RX_BITS)) phase_next = PH_RXSTOP;
                end
            PH_RXSTOP:
                if (elapsed)
                begin
                    if (!item.line_in) error_flag_next = 1'b1;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            default:
            begin
                phase_next      = PH_IDLE;
                tick_count_next = '0;
            end
        endcase
    end

    // result fields seen after this tick
    assign tx_bits_out = tx_shift_next >> bit_index_next;
    assign word        = done ? WORD_W'(rx_shift_next) : '0;

    always_comb
    begin
        res.line_out     = 1'b0;
        if ((phase_next == PH_LSTOP) || (phase_next == PH_SSTOP))
            res.line_out = 1'b1;
        else if (phase_next == PH_TXDATA)
            res.line_out = tx_bits_out[0];
        res.drive_enable = (phase_next <= PH_EXTRA);
        res.busy_res     = (phase_next != PH_IDLE);
        res.done_res     = done;
        res.ok           = done && !error_flag_next && (word != '0);
        res.rx_word      = word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            tx_shift_reg   <= '0;
            rx_shift_reg   <= '0;
            error_flag_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            tx_shift_reg   <= tx_shift_next;
            rx_shift_reg   <= rx_shift_next;
            error_flag_reg <= error_flag_next;
        end
    end

    // result register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take) skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !take) skid_valid_reg <= 1'b1;
            else out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take) out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !take) skid_reg <= res;
            else out_reg <= res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.line_out     = out_reg.line_out;
    assign result.drive_enable = out_reg.drive_enable;
    assign result.busy_res     = out_reg.busy_res;
    assign result.done_res     = out_reg.done_res;
    assign result.ok           = out_reg.ok;
    assign result.rx_word      = out_reg.rx_word;

endmodule
